### hdl/first_fit_extent_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// first fit extent allocator assertion macros
// shared property wrappers for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_TOP_DEFINES_SVH

// checked property, held off while reset is low
`define FFEA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked property, active during reset too
`define FFEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg
// types, codes and helpers shared by the extent allocator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ffea_pkg;

    localparam logic [31:0] MIN_BODY = 32'd32;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_ZERO  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_REMOVE,
        CMD_INSERT,
        CMD_MERGE_PREV,
        CMD_MERGE_NEXT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        join_next;
        logic [31:0] hdr;
        logic [31:0] size;
    } cell_cmd_t;

    typedef struct packed {
        logic [31:0] req;
        logic [33:0] rel_end;
        logic [31:0] rel_hdr;
    } query_t;

    typedef struct packed {
        logic fit;
        logic lt;
        logic eq_next;
        logic eq_prev;
    } cell_flags_t;

    typedef struct packed {
        logic [31:0] hdr;
        logic [31:0] size;
    } extent_t;

    // a + header + b, saturating at all ones
    function automatic logic [31:0] sat_join(input logic [31:0] a, input logic [31:0] b,
                                             input logic [4:0] hb);
        logic [33:0] sum;
        sum = {2'b00, a} + {29'd0, hb} + {2'b00, b};
        return (|sum[33:32]) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

### hdl/first_fit_extent_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_top
// first fit free extent allocator with split and coalescing on release
// ----------------------------------------------------------------------------
// channel | dir | content
// s_*     | in  | tdata: opcode[1:0], body_address[33:2], byte_count[65:34]
// m_*     | out | tdata: granted_address[31:0], granted_size[63:32], status[65:64]
// cfg_*   | in  | index 0 heap_start, index 1 heap_limit
//
// every beat passes accept, compare in all cells, decision and table update in turn;
// the result is loaded in the update cycle if the output is free, then the next beat
// is taken; a result held by a low m_tready keeps the block in hold until taken
// aresetn empties the table at once; there is no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_top_defines.svh"
module first_fit_extent_allocator_top #(
    parameter int MAX_EXTENTS  = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // opcode, body_address, byte_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // granted_address, granted_size, status
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ffea_pkg::*;

    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam logic [4:0] HB = 5'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_EXTENTS);

    typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_DECIDE, ST_APPLY, ST_HOLD} state_t;

    state_t           state_reg;
    logic             m_tvalid_reg;
    logic [71:0]      m_tdata_reg;
    logic [1:0]       op_reg;
    logic [31:0]      body_reg, cnt_reg;
    logic [31:0]      heap_start_reg, heap_limit_reg;
    logic [CNT_W-1:0] count_reg, count_new_reg, count_new_next;
    cell_cmd_t        cmd_reg, cmd_next;
    logic [IDX_W-1:0] cmd_idx_reg, cmd_idx_next;
    logic [31:0]      res_addr_reg, res_addr_next, res_size_reg, res_size_next;
    logic [1:0]       res_stat_reg, res_stat_next;

    query_t           query;
    cell_flags_t      flags [MAX_EXTENTS];
    extent_t          ext [MAX_EXTENTS];
    extent_t          left_ext [MAX_EXTENTS];
    extent_t          right_ext [MAX_EXTENTS];
    logic             cmd_en, out_free;

    logic [MAX_EXTENTS-1:0] fit_v, lt_v, eqn_v, eqp_v, first_fit;
    logic [MAX_EXTENTS:0]   lt_ext, p_oh;
    logic [IDX_W-1:0]       fit_idx;
    logic [CNT_W-1:0]       p_idx;
    logic [31:0]            sel_hdr, sel_size, rem, rel_hdr;
    logic                   join_next, join_prev;
    logic [33:0]            init_body;

    // ---------------------------------------------------------------- query
    assign rel_hdr       = body_reg - 32'(HEADER_BYTES);
    assign query.req     = (cnt_reg < MIN_BODY) ? MIN_BODY : cnt_reg;
    assign query.rel_hdr = rel_hdr;
    assign query.rel_end = {2'b00, rel_hdr} + {29'd0, HB} + {2'b00, cnt_reg};

    // ---------------------------------------------------------------- cell row
    assign cmd_en = state_reg == ST_APPLY;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
            if (gi == 0) begin : g_l0
                assign left_ext[gi] = '0;
            end else begin : g_l
                assign left_ext[gi] = ext[gi-1];
            end
            if (gi == MAX_EXTENTS - 1) begin : g_rn
                assign right_ext[gi] = '0;
            end else begin : g_r
                assign right_ext[gi] = ext[gi+1];
            end
            ffea_cell #(
                .IDX_W(IDX_W), .CNT_W(CNT_W), .INDEX(gi), .HEADER_BYTES(HEADER_BYTES)
            ) u_cell (
                .aclk(aclk), .count(count_reg), .query(query), .flags(flags[gi]),
                .cmd_en(cmd_en), .cmd(cmd_reg), .cmd_idx(cmd_idx_reg),
                .left_ext(left_ext[gi]), .right_ext(right_ext[gi]), .own_ext(ext[gi])
            );
            assign fit_v[gi] = flags[gi].fit;
            assign lt_v[gi]  = flags[gi].lt;
            assign eqn_v[gi] = flags[gi].eq_next;
            assign eqp_v[gi] = flags[gi].eq_prev;
        end
    endgenerate

    // ---------------------------------------------------------------- decision
    assign first_fit = fit_v & (~fit_v + 1'b1);
    assign lt_ext    = {1'b0, lt_v};
    // extents below the end form a prefix, the first zero is the insert slot
    assign p_oh      = ~lt_ext & (lt_ext + 1'b1);
    assign join_next = |(p_oh[MAX_EXTENTS-1:0] & eqn_v);
    assign join_prev = |(p_oh[MAX_EXTENTS:1] & eqp_v);

    always_comb begin
        fit_idx  = '0;
        sel_hdr  = '0;
        sel_size = '0;
        p_idx    = '0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (first_fit[i]) begin
                fit_idx  = fit_idx | IDX_W'(i);
                sel_hdr  = sel_hdr | ext[i].hdr;
                sel_size = sel_size | ext[i].size;
            end
        end
        for (int i = 0; i <= MAX_EXTENTS; i++) begin
            if (p_oh[i]) begin
                p_idx = p_idx | CNT_W'(i);
            end
        end
    end

    assign rem       = sel_size - query.req;
    assign init_body = {2'b00, heap_start_reg} + {29'd0, HB};

    always_comb begin
        cmd_next       = '0;
        cmd_next.kind  = CMD_NONE;
        cmd_idx_next   = '0;
        count_new_next = count_reg;
        res_addr_next  = '0;
        res_size_next  = '0;
        res_stat_next  = STAT_OK;
        case (opcode_t'(op_reg))
            OP_INIT: begin
                if ({2'b00, heap_limit_reg} < init_body) begin
                    count_new_next = '0;
                    res_stat_next  = STAT_NOFIT;
                end else begin
                    cmd_next.kind  = CMD_WRITE;
                    cmd_next.hdr   = heap_start_reg;
                    cmd_next.size  = heap_limit_reg - heap_start_reg - 32'(HEADER_BYTES);
                    count_new_next = CNT_W'(1);
                end
            end
            OP_ALLOC: begin
                if (cnt_reg == '0) begin
                    res_stat_next = STAT_ZERO;
                end else if (!(|fit_v)) begin
                    res_stat_next = STAT_NOFIT;
                end else begin
                    cmd_idx_next  = fit_idx;
                    res_addr_next = sel_hdr + 32'(HEADER_BYTES);
                    if (rem >= MIN_BODY) begin
                        cmd_next.kind = CMD_WRITE;
                        cmd_next.hdr  = sel_hdr + 32'(HEADER_BYTES) + query.req;
                        cmd_next.size = rem - 32'(HEADER_BYTES);
                        res_size_next = query.req;
                    end else begin
                        cmd_next.kind  = CMD_REMOVE;
                        count_new_next = count_reg - 1'b1;
                        res_size_next  = sel_size;
                    end
                end
            end
            OP_RELEASE: begin
                cmd_next.hdr  = rel_hdr;
                cmd_next.size = cnt_reg;
                if (body_reg == '0) begin
                    cmd_next.kind = CMD_NONE;
                end else if (join_prev) begin
                    cmd_next.kind      = CMD_MERGE_PREV;
                    cmd_next.join_next = join_next;
                    cmd_idx_next       = IDX_W'(p_idx - 1'b1);
                    count_new_next     = count_reg - CNT_W'(join_next);
                end else if (join_next) begin
                    cmd_next.kind = CMD_MERGE_NEXT;
                    cmd_idx_next  = IDX_W'(p_idx);
                end else if (count_reg >= FULL) begin
                    res_stat_next = STAT_FULL;
                end else begin
                    cmd_next.kind  = CMD_INSERT;
                    cmd_idx_next   = IDX_W'(p_idx);
                    count_new_next = count_reg + 1'b1;
                end
            end
            default: begin
                cmd_next.kind = CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE) begin
            cmd_reg       <= cmd_next;
            cmd_idx_reg   <= cmd_idx_next;
            count_new_reg <= count_new_next;
            res_addr_reg  <= res_addr_next;
            res_size_reg  <= res_size_next;
            res_stat_reg  <= res_stat_next;
        end
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            heap_start_reg <= '0;
            heap_limit_reg <= '0;
        end else begin
            if (cmd_en) begin
                count_reg <= count_new_reg;
            end
            if (cfg_wr_en) begin
                if (cfg_index) begin
                    heap_limit_reg <= cfg_wdata;
                end else begin
                    heap_start_reg <= cfg_wdata;
                end
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !((state_reg == ST_APPLY || state_reg == ST_HOLD) && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tdata[1:0];
                        body_reg  <= s_tdata[33:2];
                        cnt_reg   <= s_tdata[65:34];
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY, ST_HOLD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, res_stat_reg, res_size_reg, res_addr_reg};
                        state_reg    <= ST_IDLE;
                    end else begin
                        state_reg <= ST_HOLD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- checks
    `FFEA_ASSERT(a_count_range, aclk, aresetn, count_reg <= FULL, "extent count above table size")
    `FFEA_ASSERT(a_accept_eval, aclk, aresetn, (s_tvalid && s_tready) |=> state_reg == ST_EVAL, "accepted beat did not start compare")
    `FFEA_ASSERT(a_count_upd, aclk, aresetn, !$stable(count_reg) |-> $past(state_reg == ST_APPLY), "count changed outside table update")
    `FFEA_ASSERT(a_result_src, aclk, aresetn, $rose(m_tvalid) |-> ($past(state_reg == ST_APPLY) || $past(state_reg == ST_HOLD)), "result raised without a finished beat")

endmodule

### hdl/ffea_cell.sv
// ----------------------------------------------------------------------------
// ffea_cell
// one table slot: holds an extent, compares it against the query and
// shifts to or from its neighbors on a table update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ffea_cell #(
    parameter int IDX_W        = 4,
    parameter int CNT_W        = 5,
    parameter int INDEX        = 0,
    parameter int HEADER_BYTES = 8
) (
    input  logic                 aclk,
    input  logic [CNT_W-1:0]     count,
    input  ffea_pkg::query_t     query,
    output ffea_pkg::cell_flags_t flags,
    input  logic                 cmd_en,
    input  ffea_pkg::cell_cmd_t  cmd,
    input  logic [IDX_W-1:0]     cmd_idx,
    input  ffea_pkg::extent_t    left_ext,
    input  ffea_pkg::extent_t    right_ext,
    output ffea_pkg::extent_t    own_ext
);
    import ffea_pkg::*;

    localparam logic [4:0] HB = 5'(HEADER_BYTES);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    extent_t     ext_reg, ext_next;
    cell_flags_t flags_reg, flags_next;
    logic        valid, sel, above;
    logic [31:0] merged;

    assign valid = count > CNT_W'(INDEX);
    assign sel   = cmd_idx == MY_IDX;
    assign above = MY_IDX > cmd_idx;

    always_comb begin
        flags_next.fit     = valid && (ext_reg.size >= query.req);
        flags_next.lt      = valid && ({2'b00, ext_reg.hdr} < query.rel_end);
        flags_next.eq_next = valid && ({2'b00, ext_reg.hdr} == query.rel_end);
        flags_next.eq_prev = valid && (({2'b00, ext_reg.hdr} + {29'd0, HB} +
                             {2'b00, ext_reg.size}) == {2'b00, query.rel_hdr});
    end

    // preceding merge absorbs the released block and maybe the right neighbor
    assign merged = sat_join(ext_reg.size,
                             cmd.join_next ? sat_join(cmd.size, right_ext.size, HB) : cmd.size,
                             HB);

    always_comb begin
        ext_next = ext_reg;
        if (cmd_en) begin
            case (cmd.kind)
                CMD_WRITE: begin
                    if (sel) begin
                        ext_next.hdr  = cmd.hdr;
                        ext_next.size = cmd.size;
                    end
                end
                CMD_REMOVE: begin
                    if (sel || above) begin
                        ext_next = right_ext;
                    end
                end
                CMD_INSERT: begin
                    if (sel) begin
                        ext_next.hdr  = cmd.hdr;
                        ext_next.size = cmd.size;
                    end else if (above) begin
                        ext_next = left_ext;
                    end
                end
                CMD_MERGE_PREV: begin
                    if (sel) begin
                        ext_next.size = merged;
                    end else if (above && cmd.join_next) begin
                        ext_next = right_ext;
                    end
                end
                CMD_MERGE_NEXT: begin
                    if (sel) begin
                        ext_next.hdr  = cmd.hdr;
                        ext_next.size = sat_join(cmd.size, ext_reg.size, HB);
                    end
                end
                default: begin
                    ext_next = ext_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        ext_reg   <= ext_next;
        flags_reg <= flags_next;
    end

    assign own_ext = ext_reg;
    assign flags   = flags_reg;

endmodule
